// File: rtl/core/adsr_envelope_generator_unit_assert.svh
`ifndef ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH

// Assertion checked only while the reset is released.
`define ADSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion checked at every clock edge, reset included.
`define ADSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/adsr_pkg.sv
package adsr_pkg;

  localparam int DEBOUNCE_LIMIT = 8;
  localparam int SUSTAIN_HOLD   = 4;

  localparam int INTEG_W = $clog2(DEBOUNCE_LIMIT + 1) + 1;
  localparam int LEN_W   = 12;
  localparam int TICK_W  = 13;
  localparam int LVL_W   = 12;
  localparam int QUO_W   = 10;
  localparam int NUM_W   = LEN_W + QUO_W;
  localparam int STEP_W  = $clog2(QUO_W);

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX  = INTEG_W'(DEBOUNCE_LIMIT);
  localparam logic signed [INTEG_W-1:0] INTEG_MIN  = -INTEG_MAX;
  localparam logic signed [INTEG_W-1:0] INTEG_HOLD = INTEG_W'(SUSTAIN_HOLD);

  localparam logic [LVL_W-1:0] LVL_ZERO    = 12'd2048;
  localparam logic [LVL_W-1:0] LVL_PEAK    = 12'd3008;
  localparam logic [LVL_W-1:0] LVL_SUST    = 12'd2528;
  localparam logic [LVL_W-1:0] GATE_THRESH = 12'd2528;

  localparam logic [QUO_W-1:0] SPAN_FULL = 10'd960;
  localparam logic [QUO_W-1:0] SPAN_HALF = 10'd480;

  localparam logic REG_PERCUSSION = 1'b0;

  typedef enum logic [2:0] {
    STG_IDLE    = 3'd0,
    STG_ATTACK  = 3'd1,
    STG_DECAY   = 3'd2,
    STG_SUSTAIN = 3'd3,
    STG_RELEASE = 3'd4
  } stage_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
  } adsr_cmd_t;

  typedef struct packed {
    logic div_last;
  } adsr_sts_t;

endpackage

// File: rtl/core/adsr_envelope_generator_unit.sv
// An accepted sample tick passes through the multiply, divide and done states;
// no new tick is taken until the controller is idle again. A ten-step restoring
// divider scales the stage position into a level, one quotient bit per cycle.
// A waiting result does not block the next tick, which then holds before output.
// Reset (asynchronous, active low) returns the envelope to idle, clears the
// gate integrator, the gate latch, the tick counter and the percussion mode.
module adsr_envelope_generator_unit import adsr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // gate_level, attack_length, decay_length, release_length
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // level, stage, zero padding
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   psel_i,
  input  logic                   penable_i,
  input  logic                   pwrite_i,
  input  logic [APB_ADDR_W-1:0]  paddr_i,
  input  logic [APB_DATA_W-1:0]  pwdata_i,
  output logic [APB_DATA_W-1:0]  prdata_o,
  output logic                   pready_o
);

  adsr_cmd_t        cmd;
  adsr_sts_t        sts;
  logic             percussion_q;
  logic             cfg_sel;
  logic             in_ready;
  logic [LVL_W-1:0] level;
  stage_e           stage;

  assign pready_o = 1'b1;
  assign cfg_sel  = (paddr_i[APB_ADDR_W-1] == REG_PERCUSSION);
  assign prdata_o = cfg_sel ? {{(APB_DATA_W-1){1'b0}}, percussion_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      percussion_q <= 1'b0;
    end else if (psel_i && penable_i && pwrite_i && cfg_sel) begin
      percussion_q <= pwdata_i[0];
    end
  end

  adsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (in_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  adsr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .percussion_i     (percussion_q),
    .gate_level_i     (s_axis_tdata_i[11:0]),
    .attack_length_i  (s_axis_tdata_i[23:12]),
    .decay_length_i   (s_axis_tdata_i[35:24]),
    .release_length_i (s_axis_tdata_i[47:36]),
    .level_o          (level),
    .stage_o          (stage)
  );

  assign s_axis_tready_o = in_ready;
  assign m_axis_tdata_o  = {1'b0, stage, level};

endmodule

// File: rtl/core/adsr_ctrl.sv
module adsr_ctrl import adsr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  adsr_sts_t sts_i,
  output adsr_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/adsr_datapath.sv
module adsr_datapath import adsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  adsr_cmd_t        cmd_i,
  output adsr_sts_t        sts_o,
  input  logic             percussion_i,
  input  logic [LEN_W-1:0] gate_level_i,
  input  logic [LEN_W-1:0] attack_length_i,
  input  logic [LEN_W-1:0] decay_length_i,
  input  logic [LEN_W-1:0] release_length_i,
  output logic [LVL_W-1:0] level_o,
  output stage_e           stage_o
);

  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic                      latched_q, latched_d;
  stage_e                    stage_q, stage_d;
  logic [TICK_W-1:0]         tick_q, tick_d;

  logic [LEN_W-1:0]  op_tick_q, op_tick_d;
  logic              op_full_q, op_full_d;
  logic [LEN_W-1:0]  divisor_q, divisor_d;
  logic [LVL_W-1:0]  base_q, base_d;
  logic              up_q, up_d;

  logic [LEN_W-1:0]  rem_q;
  logic [QUO_W-1:0]  dvd_q;
  logic [QUO_W-1:0]  quo_q;
  logic [STEP_W-1:0] cnt_q;
  logic [LVL_W-1:0]  level_q;
  stage_e            res_stage_q;

  logic signed [INTEG_W-1:0] integ_up;
  logic                      rise;
  logic                      latched_mid;
  stage_e                    stage_mid;
  logic [TICK_W-1:0]         tick_mid;

  logic [NUM_W-1:0] product;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             ge;

  always_comb begin
    integ_up = integ_q;
    if ((gate_level_i > GATE_THRESH) && (integ_q < INTEG_MAX)) begin
      integ_up = integ_q + INTEG_W'(1);
    end
    rise        = (integ_up == INTEG_MAX) && !latched_q;
    stage_mid   = rise ? STG_ATTACK : stage_q;
    tick_mid    = rise ? '0 : tick_q;
    latched_mid = rise ? 1'b1 : latched_q;
    integ_d     = integ_up;
    if ((gate_level_i < GATE_THRESH) && (integ_up > INTEG_MIN)) begin
      integ_d = integ_up - INTEG_W'(1);
    end
    latched_d = latched_mid;
    if ((integ_d == INTEG_MIN) && latched_mid) begin
      latched_d = 1'b0;
    end

    stage_d   = stage_mid;
    tick_d    = tick_mid + TICK_W'(1);
    op_tick_d = '0;
    op_full_d = 1'b0;
    divisor_d = LEN_W'(1);
    base_d    = LVL_ZERO;
    up_d      = 1'b1;

    if (stage_d == STG_ATTACK) begin
      if (tick_d < TICK_W'(attack_length_i)) begin
        op_tick_d = tick_d[LEN_W-1:0];
        op_full_d = 1'b1;
        divisor_d = attack_length_i;
      end else begin
        stage_d = STG_DECAY;
        tick_d  = '0;
      end
    end
    if (stage_d == STG_DECAY) begin
      if (tick_d < TICK_W'(decay_length_i)) begin
        op_tick_d = tick_d[LEN_W-1:0];
        divisor_d = decay_length_i;
        base_d    = LVL_PEAK;
        up_d      = 1'b0;
      end else begin
        stage_d = percussion_i ? STG_RELEASE : STG_SUSTAIN;
        tick_d  = '0;
      end
    end
    if (stage_d == STG_SUSTAIN) begin
      if ((integ_d > INTEG_HOLD) && latched_d) begin
        base_d = LVL_SUST;
      end else begin
        stage_d = STG_RELEASE;
        tick_d  = '0;
      end
    end
    if (stage_d == STG_RELEASE) begin
      if (tick_d < TICK_W'(release_length_i)) begin
        op_tick_d = tick_d[LEN_W-1:0];
        divisor_d = release_length_i;
        base_d    = LVL_SUST;
        up_d      = 1'b0;
      end else begin
        stage_d   = STG_IDLE;
        tick_d    = '0;
        base_d    = LVL_ZERO;
        up_d      = 1'b1;
      end
    end
  end

  assign product = NUM_W'(op_tick_q) * NUM_W'(op_full_q ? SPAN_FULL : SPAN_HALF);
  assign trial   = {rem_q, dvd_q[QUO_W-1]};
  assign diff    = trial - {1'b0, divisor_q};
  assign ge      = (trial >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q   <= '0;
      latched_q <= 1'b0;
      stage_q   <= STG_IDLE;
      tick_q    <= '0;
      cnt_q     <= '0;
    end else begin
      if (cmd_i.load) begin
        integ_q   <= integ_d;
        latched_q <= latched_d;
        stage_q   <= stage_d;
        tick_q    <= tick_d;
      end
      if (cmd_i.mul) begin
        cnt_q <= '0;
      end else if (cmd_i.step) begin
        cnt_q <= cnt_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_tick_q   <= op_tick_d;
      op_full_q   <= op_full_d;
      divisor_q   <= divisor_d;
      base_q      <= base_d;
      up_q        <= up_d;
    end
    if (cmd_i.mul) begin
      rem_q <= product[NUM_W-1:QUO_W];
      dvd_q <= product[QUO_W-1:0];
    end else if (cmd_i.step) begin
      rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      dvd_q <= {dvd_q[QUO_W-2:0], 1'b0};
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
    if (cmd_i.finish) begin
      level_q     <= up_q ? (base_q + LVL_W'(quo_q)) : (base_q - LVL_W'(quo_q));
      res_stage_q <= stage_q;
    end
  end

  assign sts_o.div_last = (cnt_q == STEP_W'(QUO_W - 1));
  assign level_o        = level_q;
  assign stage_o        = res_stage_q;

endmodule

// File: rtl/core/adsr_chk.sv
`include "adsr_envelope_generator_unit_assert.svh"

module adsr_chk import adsr_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  `ADSR_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "Stalled result changed")
  `ADSR_ASSERT(a_level_range, clk_i, rst_ni, m_axis_tvalid_o |-> (m_axis_tdata_o[11:0] >= LVL_ZERO) && (m_axis_tdata_o[11:0] <= LVL_PEAK), "Level out of range")
  `ADSR_ASSERT(a_idle_level, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[14:12] == STG_IDLE) |-> m_axis_tdata_o[11:0] == LVL_ZERO, "Idle level is not zero volts")
  `ADSR_ASSERT(a_one_at_a_time, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "Tick accepted while one is in progress")
  `ADSR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "Result offered during reset")

endmodule

bind adsr_envelope_generator_unit adsr_chk u_adsr_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
